FILE: hw/rtl/sts_pkg.sv
// -----------------------------------------------------------------------------
// sts_pkg
// Shared types, character codes and class helpers for the s-expression
// token scanner.
// -----------------------------------------------------------------------------
package sts_pkg;

    localparam int unsigned POS_BITS_DEF = 16;
    localparam int unsigned CNT_BITS     = 16;
    localparam int unsigned NUM_RES      = 3;

    // scan modes
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_INT     = 2'd1;
    localparam logic [1:0] MODE_IDENT   = 2'd2;
    localparam logic [1:0] MODE_COMMENT = 2'd3;

    // token kinds
    localparam logic [2:0] KIND_LPAREN = 3'd0;
    localparam logic [2:0] KIND_RPAREN = 3'd1;
    localparam logic [2:0] KIND_INT    = 3'd2;
    localparam logic [2:0] KIND_IDENT  = 3'd3;
    localparam logic [2:0] KIND_END    = 3'd4;

    // configuration register indexes
    localparam logic CFG_FIRST_LINE   = 1'b0;
    localparam logic CFG_FIRST_COLUMN = 1'b1;

    localparam logic [15:0] FIRST_LINE_RST   = 16'd1;
    localparam logic [15:0] FIRST_COLUMN_RST = 16'd0;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] start_pos;
        logic [15:0] end_pos;
        logic [15:0] line_no;
        logic [15:0] col_no;
    } t_token;

    typedef struct packed {
        logic       vld;
        logic [1:0] cnt;
    } t_push;

    function automatic logic is_dig(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_let(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic ident_more(input logic [7:0] b);
        return is_let(b) || is_dig(b) || (b == CH_UNDER) || (b == CH_MINUS);
    endfunction

    function automatic logic [15:0] cnt_inc(input logic [15:0] c);
        return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

endpackage

FILE: hw/rtl/sexpr_token_scanner.sv
// A byte is taken into the input register; its token words are then loaded
// into the result bank and presented from there.
// Throughput: one byte per cycle while each byte yields at most one token and
// the output takes each word; a byte with more than one token stalls the input.
// Reset: i_rst_n is synchronous, active low; clears the scanner to idle,
// positions to 0, line/column registers to 1/0, and empties the result bank.
// -----------------------------------------------------------------------------
// sexpr_token_scanner
// Streaming s-expression lexer: one source byte in, tokens out.
// -----------------------------------------------------------------------------
module sexpr_token_scanner #(
    parameter int unsigned POS_BITS = sts_pkg::POS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,   // final_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [15:0] start_pos, [31:16] end_pos,
                                        // [47:32] line_no, [63:48] col_no
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast,   // run_last
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    sts_pkg::t_push  push;
    sts_pkg::t_token res [sts_pkg::NUM_RES];
    sts_pkg::t_token tok;
    logic            space;

    assign o_cfg_ready = 1'b1;

    sts_core #(
        .POS_BITS (POS_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_ch        (s_axis_tdata),
        .i_final     (s_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_space     (space),
        .o_push      (push),
        .o_res       (res)
    );

    sts_res_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .o_space (space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_tok   (tok),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tuser = tok.kind;
    assign m_axis_tdata = {tok.col_no, tok.line_no, tok.end_pos, tok.start_pos};

endmodule

FILE: hw/rtl/sts_core.sv
// -----------------------------------------------------------------------------
// sts_core
// Input byte register, scanner state and the per-byte token step. Produces up
// to three tokens per byte for the result buffer.
// -----------------------------------------------------------------------------
module sts_core #(
    parameter int unsigned POS_BITS = sts_pkg::POS_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_ch,
    input  logic                        i_final,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_index,
    input  logic [15:0]                 i_cfg_data,
    input  logic                        i_space,
    output sts_pkg::t_push              o_push,
    output sts_pkg::t_token             o_res [sts_pkg::NUM_RES]
);

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    logic                r_in_valid;
    logic [7:0]          r_ch;
    logic                r_fin;
    logic [1:0]          r_mode,  n_mode;
    logic [POS_BITS-1:0] r_pos,   n_pos;
    logic [POS_BITS-1:0] r_tok,   n_tok;
    logic [15:0]         r_line,  n_line;
    logic [15:0]         r_col,   n_col;
    logic [15:0]         r_first_line;
    logic [15:0]         r_first_col;

    logic                proceed;
    logic                accept;
    logic [1:0]          n_cnt;
    sts_pkg::t_token     res [sts_pkg::NUM_RES];

    function automatic logic [15:0] low16(input logic [POS_BITS-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        return w[15:0];
    endfunction

    function automatic logic [POS_BITS-1:0] pos_inc(input logic [POS_BITS-1:0] p);
        return (p == POS_MAX) ? p : p + POS_BITS'(1);
    endfunction

    assign proceed    = r_in_valid && i_space;
    assign o_in_ready = !r_in_valid || proceed;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        logic                flush;
        logic [1:0]          mode1;
        logic [15:0]         line1;
        logic [15:0]         col1;
        logic [15:0]         col2;
        logic [POS_BITS-1:0] pos2;
        logic [1:0]          k;
        flush = ((r_mode == sts_pkg::MODE_INT)   && !sts_pkg::is_dig(r_ch)) ||
                ((r_mode == sts_pkg::MODE_IDENT) && !sts_pkg::ident_more(r_ch));
        k     = 2'd0;
        for (int i = 0; i < sts_pkg::NUM_RES; i++) begin
            res[i] = '0;
        end
        n_tok = r_tok;
        line1 = r_line;
        col1  = r_col;

        if (flush) begin
            res[k] = '{
                kind:      (r_mode == sts_pkg::MODE_INT) ? sts_pkg::KIND_INT
                                                         : sts_pkg::KIND_IDENT,
                start_pos: low16(r_tok),
                end_pos:   low16(r_pos),
                line_no:   r_line,
                col_no:    r_col};
            k = k + 2'd1;
        end

        if (flush || ((r_mode == sts_pkg::MODE_COMMENT) && (r_ch == sts_pkg::CH_NL))) begin
            mode1 = sts_pkg::MODE_IDLE;
        end else begin
            mode1 = r_mode;
        end
        n_mode = mode1;

        if (mode1 == sts_pkg::MODE_IDLE) begin
            if (r_ch == sts_pkg::CH_NL) begin
                line1 = sts_pkg::cnt_inc(r_line);
                col1  = 16'd0;
            end else if ((r_ch == sts_pkg::CH_LPAREN) || (r_ch == sts_pkg::CH_RPAREN)) begin
                res[k] = '{
                    kind:      (r_ch == sts_pkg::CH_LPAREN) ? sts_pkg::KIND_LPAREN
                                                            : sts_pkg::KIND_RPAREN,
                    start_pos: low16(r_pos),
                    end_pos:   low16(pos_inc(r_pos)),
                    line_no:   r_line,
                    col_no:    sts_pkg::cnt_inc(r_col)};
                k = k + 2'd1;
            end else if (r_ch == sts_pkg::CH_SEMI) begin
                n_mode = sts_pkg::MODE_COMMENT;
            end else if (sts_pkg::is_dig(r_ch) || (r_ch == sts_pkg::CH_MINUS)) begin
                n_mode = sts_pkg::MODE_INT;
                n_tok  = r_pos;
            end else if (sts_pkg::is_let(r_ch) || (r_ch == sts_pkg::CH_UNDER)) begin
                n_mode = sts_pkg::MODE_IDENT;
                n_tok  = r_pos;
            end
        end

        col2   = sts_pkg::cnt_inc(col1);
        pos2   = pos_inc(r_pos);
        n_line = line1;
        n_col  = col2;
        n_pos  = pos2;

        if (r_fin) begin
            if ((n_mode == sts_pkg::MODE_INT) || (n_mode == sts_pkg::MODE_IDENT)) begin
                res[k] = '{
                    kind:      (n_mode == sts_pkg::MODE_INT) ? sts_pkg::KIND_INT
                                                             : sts_pkg::KIND_IDENT,
                    start_pos: low16(n_tok),
                    end_pos:   low16(pos2),
                    line_no:   line1,
                    col_no:    col2};
                k = k + 2'd1;
            end
            res[k] = '{
                kind:      sts_pkg::KIND_END,
                start_pos: low16(pos2),
                end_pos:   low16(pos2),
                line_no:   line1,
                col_no:    col2};
            k = k + 2'd1;
            // restart for the next source
            n_mode = sts_pkg::MODE_IDLE;
            n_pos  = '0;
            n_tok  = '0;
            n_line = r_first_line;
            n_col  = r_first_col;
        end
        n_cnt = k;
    end

    assign o_push = '{vld: proceed, cnt: n_cnt};
    assign o_res  = res;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ch  <= i_ch;
            r_fin <= i_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_mode       <= sts_pkg::MODE_IDLE;
            r_pos        <= '0;
            r_tok        <= '0;
            r_line       <= sts_pkg::FIRST_LINE_RST;
            r_col        <= sts_pkg::FIRST_COLUMN_RST;
            r_first_line <= sts_pkg::FIRST_LINE_RST;
            r_first_col  <= sts_pkg::FIRST_COLUMN_RST;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (proceed) begin
                r_in_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                if (i_cfg_index == sts_pkg::CFG_FIRST_LINE) begin
                    r_first_line <= i_cfg_data;
                end else begin
                    r_first_col <= i_cfg_data;
                end
            end

            if (proceed) begin
                r_mode <= n_mode;
                r_pos  <= n_pos;
                r_tok  <= n_tok;
                r_line <= n_line;
                r_col  <= n_col;
            end else if (i_cfg_valid && (r_pos == '0)) begin
                // nothing consumed yet: the write also loads the live count
                if (i_cfg_index == sts_pkg::CFG_FIRST_LINE) begin
                    r_line <= i_cfg_data;
                end else begin
                    r_col <= i_cfg_data;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/sts_res_buf.sv
// -----------------------------------------------------------------------------
// sts_res_buf
// Result register bank: holds the tokens of one byte and hands them out one
// word per handshake, marking the last one.
// -----------------------------------------------------------------------------
module sts_res_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sts_pkg::t_push   i_push,
    input  sts_pkg::t_token  i_res [sts_pkg::NUM_RES],
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output sts_pkg::t_token  o_tok,
    output logic             o_last
);

    sts_pkg::t_token r_res [sts_pkg::NUM_RES];
    logic [1:0]      r_left;
    logic [1:0]      r_rd;
    logic            pop;

    assign o_valid = (r_left != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_space = (r_left == 2'd0) || ((r_left == 2'd1) && pop);
    assign o_tok   = r_res[r_rd];
    assign o_last  = (r_left == 2'd1);

    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_res <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
            r_rd   <= 2'd0;
        end else if (i_push.vld) begin
            r_left <= i_push.cnt;
            r_rd   <= 2'd0;
        end else if (pop) begin
            r_left <= r_left - 2'd1;
            r_rd   <= r_rd + 2'd1;
        end
    end

endmodule

FILE: hw/rtl/sts_checker.sv
// -----------------------------------------------------------------------------
// sts_checker
// Port-level checks on the token scanner, bound to the top level.
// -----------------------------------------------------------------------------
module sts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid straight after reset");

    // end token always closes the byte's run
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == sts_pkg::KIND_END) |-> m_axis_tlast)
        else $error("end token without last");

    a_end_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == sts_pkg::KIND_END) |->
            (m_axis_tdata[15:0] == m_axis_tdata[31:16]))
        else $error("end token with non-empty span");

endmodule

bind sexpr_token_scanner sts_checker u_sts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/sv/tb_sexpr_token_scanner.sv
// -----------------------------------------------------------------------------
// tb_sexpr_token_scanner
// Self-checking bench for the s-expression token scanner. Source bytes are
// streamed in short runs of well-formed text with noise mixed in. A local lexer
// model tracks mode, position, line and column, and queues the token words that
// each byte should produce. Every word leaving the block is checked against the
// oldest queued word. Between runs the bench drains and rewrites the start line
// and start column registers, including extreme values.
// -----------------------------------------------------------------------------
module tb_sexpr_token_scanner;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic       fin;
        logic [7:0] ch;
    } t_src_word;

    typedef struct packed {
        sts_pkg::t_token tok;
        logic            last;
    } t_tok_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = sts_pkg::CFG_FIRST_LINE;
    logic [15:0] i_cfg_data = '0;

    sexpr_token_scanner u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // lexer model state
    logic [1:0]  sc_mode = sts_pkg::MODE_IDLE;
    logic [15:0] sc_pos = '0;
    logic [15:0] sc_start = '0;
    logic [15:0] sc_line = sts_pkg::FIRST_LINE_RST;
    logic [15:0] sc_col = sts_pkg::FIRST_COLUMN_RST;
    logic [15:0] reg_first_line = sts_pkg::FIRST_LINE_RST;
    logic [15:0] reg_first_col = sts_pkg::FIRST_COLUMN_RST;

    t_src_word src_q[$];
    t_tok_word token_q[$];

    int n_pushed = 0;
    int n_taken = 0;
    int n_cfg_taken = 0;
    int err_count = 0;
    int src_gap = 0;
    int sink_gap = 0;
    int hold_left = 0;
    logic in_taken = 1'b0;
    logic idle_on = 1'b1;
    logic hold_req = 1'b0;
    t_src_word drv_word;
    t_tok_word got, want;

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic tb_num_char(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic tb_letter_char(input logic [7:0] b);
        return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic ident_char(input logic [7:0] b);
        return tb_letter_char(b) || tb_num_char(b) || b == sts_pkg::CH_UNDER ||
               b == sts_pkg::CH_MINUS;
    endfunction

    function automatic string tok_str(input t_tok_word w);
        return $sformatf("kind %0d start %0d end %0d line %0d col %0d last %0b",
                         w.tok.kind, w.tok.start_pos, w.tok.end_pos,
                         w.tok.line_no, w.tok.col_no, w.last);
    endfunction

    // Advance the lexer model by one byte and queue the token words it yields.
    function automatic void scan_byte(input logic [7:0] b, input logic fin);
        sts_pkg::t_token toks[3];
        t_tok_word   w;
        logic [15:0] p;
        logic [2:0]  pend_kind;
        int n;
        int i;
        n = 0;
        p = sc_pos;
        pend_kind = (sc_mode == sts_pkg::MODE_INT) ? sts_pkg::KIND_INT
                                                   : sts_pkg::KIND_IDENT;
        if (sc_mode == sts_pkg::MODE_INT || sc_mode == sts_pkg::MODE_IDENT) begin
            if (sc_mode == sts_pkg::MODE_INT ? !tb_num_char(b) : !ident_char(b)) begin
                // pending token closes with the counts before this byte
                toks[n] = '{pend_kind, sc_start, p, sc_line, sc_col};
                n++;
                sc_mode = sts_pkg::MODE_IDLE;
            end
        end else if (sc_mode == sts_pkg::MODE_COMMENT && b == sts_pkg::CH_NL) begin
            sc_mode = sts_pkg::MODE_IDLE;
        end
        if (sc_mode == sts_pkg::MODE_IDLE) begin
            if (b == sts_pkg::CH_NL) begin
                sc_line = bump(sc_line);
                sc_col = '0;
            end else if (b == sts_pkg::CH_LPAREN || b == sts_pkg::CH_RPAREN) begin
                toks[n] = '{(b == sts_pkg::CH_LPAREN) ? sts_pkg::KIND_LPAREN
                                                      : sts_pkg::KIND_RPAREN,
                            p, bump(p), sc_line, bump(sc_col)};
                n++;
            end else if (b == sts_pkg::CH_SEMI) begin
                sc_mode = sts_pkg::MODE_COMMENT;
            end else if (tb_num_char(b) || b == sts_pkg::CH_MINUS) begin
                sc_mode = sts_pkg::MODE_INT;
                sc_start = p;
            end else if (tb_letter_char(b) || b == sts_pkg::CH_UNDER) begin
                sc_mode = sts_pkg::MODE_IDENT;
                sc_start = p;
            end
        end
        sc_col = bump(sc_col);
        sc_pos = bump(p);
        if (fin) begin
            if (sc_mode == sts_pkg::MODE_INT || sc_mode == sts_pkg::MODE_IDENT) begin
                toks[n] = '{(sc_mode == sts_pkg::MODE_INT) ? sts_pkg::KIND_INT
                                                           : sts_pkg::KIND_IDENT,
                            sc_start, sc_pos, sc_line, sc_col};
                n++;
            end
            toks[n] = '{sts_pkg::KIND_END, sc_pos, sc_pos, sc_line, sc_col};
            n++;
            sc_mode = sts_pkg::MODE_IDLE;
            sc_pos = '0;
            sc_start = '0;
            sc_line = reg_first_line;
            sc_col = reg_first_col;
        end
        for (i = 0; i < n; i++) begin
            w.tok = toks[i];
            w.last = (i == n - 1);
            token_q.push_back(w);
        end
    endfunction

    // input and output sampling, model update
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            in_taken = s_axis_tvalid && s_axis_tready;
            if (in_taken) begin
                scan_byte(s_axis_tdata, s_axis_tlast);
                n_taken++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                // counts follow the register only before the first byte
                if (i_cfg_index == sts_pkg::CFG_FIRST_LINE) begin
                    reg_first_line = i_cfg_data;
                    if (sc_pos == '0)
                        sc_line = i_cfg_data;
                end else begin
                    reg_first_col = i_cfg_data;
                    if (sc_pos == '0)
                        sc_col = i_cfg_data;
                end
                n_cfg_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.tok = '{m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                            m_axis_tdata[47:32], m_axis_tdata[63:48]};
                got.last = m_axis_tlast;
                if (token_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%t unexpected word: %s", $realtime, tok_str(got));
                end else begin
                    want = token_q.pop_front();
                    if (got !== want) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("%t mismatch: exp %s", $realtime, tok_str(want));
                            $display("%t           got %s", $realtime, tok_str(got));
                        end
                    end
                end
            end
        end
    end

    // byte source
    always @(negedge i_clk) begin
        if (s_axis_tvalid && !in_taken) begin
            // word still on offer
        end else if (src_gap > 0) begin
            src_gap--;
            s_axis_tvalid <= 1'b0;
        end else if (src_q.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
            src_gap = $urandom_range(0, 2);
            s_axis_tvalid <= 1'b0;
        end else if (src_q.size() != 0) begin
            drv_word = src_q.pop_front();
            s_axis_tdata <= drv_word.ch;
            s_axis_tlast <= drv_word.fin;
            s_axis_tvalid <= 1'b1;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // token sink: random bursts plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 80;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            sink_gap = $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic fin);
        src_q.push_back('{fin, b});
        n_pushed++;
    endtask

    task automatic push_text(input string s, input bit fin_last);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], fin_last && i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_ident_head();
        case ($urandom_range(0, 2))
            0:       return 8'h61 + 8'($urandom_range(0, 25));
            1:       return 8'h41 + 8'($urandom_range(0, 25));
            default: return sts_pkg::CH_UNDER;
        endcase
    endfunction

    function automatic logic [7:0] rand_ident_tail();
        case ($urandom_range(0, 4))
            0:       return 8'h30 + 8'($urandom_range(0, 9));
            1:       return sts_pkg::CH_MINUS;
            default: return rand_ident_head();
        endcase
    endfunction

    // Random source text: mostly well-formed tokens, comments and spacing,
    // with some raw bytes mixed in.
    task automatic push_source(input int len, input bit with_final);
        logic [7:0] txt[$];
        int k;
        int i;
        while (txt.size() < len) begin
            case ($urandom_range(0, 9))
                0, 1: txt.push_back(sts_pkg::CH_LPAREN);
                2: txt.push_back(sts_pkg::CH_RPAREN);
                3: begin
                    if ($urandom_range(0, 2) == 0)
                        txt.push_back(sts_pkg::CH_MINUS);
                    k = $urandom_range(0, 5);
                    repeat (k) txt.push_back(8'h30 + 8'($urandom_range(0, 9)));
                end
                4, 5: begin
                    txt.push_back(rand_ident_head());
                    k = $urandom_range(0, 6);
                    repeat (k) txt.push_back(rand_ident_tail());
                end
                6: begin
                    txt.push_back(sts_pkg::CH_SEMI);
                    k = $urandom_range(0, 6);
                    repeat (k) txt.push_back(8'($urandom_range(11, 255)));
                    if ($urandom_range(0, 3) != 0)
                        txt.push_back(sts_pkg::CH_NL);
                end
                7: begin
                    case ($urandom_range(0, 2))
                        0:       txt.push_back(CH_SPACE);
                        1:       txt.push_back(sts_pkg::CH_TAB);
                        default: txt.push_back(sts_pkg::CH_NL);
                    endcase
                end
                default: txt.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        for (i = 0; i < txt.size(); i++)
            push_byte(txt[i], with_final && i == txt.size() - 1);
    endtask

    // all bytes taken, all tokens seen, then let the pipeline settle
    task automatic wait_idle();
        do @(negedge i_clk); while (n_taken != n_pushed || token_q.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        int target;
        target = n_cfg_taken + 1;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(negedge i_clk); while (n_cfg_taken != target);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every class, comment, raw 00/FF, three words from one byte
        push_text("(az_-9 -12x;c)AZ\n", 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_text("\t09)", 1'b1);
        wait_idle();

        // top values loaded straight into the counts: saturation on both
        write_reg(sts_pkg::CFG_FIRST_LINE, 16'hFFFF);
        write_reg(sts_pkg::CFG_FIRST_COLUMN, 16'hFFFF);
        push_source(60, 1'b1);
        wait_idle();

        write_reg(sts_pkg::CFG_FIRST_LINE, 16'h0000);
        write_reg(sts_pkg::CFG_FIRST_COLUMN, 16'h0000);
        @(posedge i_clk);
        hold_req = 1'b1;
        push_source(70, 1'b0);
        wait_idle();

        // mid-source: registers change, counts carry on
        write_reg(sts_pkg::CFG_FIRST_LINE, 16'd7);
        write_reg(sts_pkg::CFG_FIRST_COLUMN, 16'd300);
        push_source(60, 1'b1);
        wait_idle();

        // integer left open up to the final byte
        write_reg(sts_pkg::CFG_FIRST_LINE, 16'd40000);
        write_reg(sts_pkg::CFG_FIRST_COLUMN, 16'd1);
        push_text("abcdefghij(7", 1'b1);
        wait_idle();

        push_source(70, 1'b1);
        wait_idle();

        @(posedge i_clk);
        idle_on = 1'b0;
        push_source(80, 1'b1);
        wait_idle();

        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
